// ===== hw/rtl/signed_binary_to_ascii_decimal_defines.svh =====
// assertion macros used by the port checker
`ifndef SIGNED_BINARY_TO_ASCII_DECIMAL_DEFINES_SVH
`define SIGNED_BINARY_TO_ASCII_DECIMAL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SBAD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SBAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sbad_pkg.sv =====
// types and constants shared by the decimal text converter
package sbad_pkg;

  localparam int MAG_W         = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS     = MAG_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(NUM_STEPS);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // one converted number waiting to be printed, digits left-aligned
  typedef struct packed {
    logic               neg;
    logic [3:0]         ndig;
    logic [BCD_W-1:0]   digits;
  } q_entry_t;

endpackage

// ===== hw/rtl/sbad_queue.sv =====
// small queue of converted numbers between the front and back parts
module sbad_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sbad_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output sbad_pkg::q_entry_t pop_data,
  output logic              empty
);
  import sbad_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sbad_front.sv =====
// front part: takes a word, forms the magnitude and converts it to bcd
module sbad_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               push,
  output sbad_pkg::q_entry_t push_data,
  input  logic               full
);
  import sbad_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

  state_t             state;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [BCD_W-1:0]   bcd;
  logic [STEP_W-1:0]  step;
  logic [BCD_W-1:0]   bcd_next;
  logic [3:0]         ndig;
  logic [3:0]         lz;
  logic               accept;

  assign push     = (state == ST_PUSH) && !full;
  assign in_stall = !((state == ST_IDLE) || push);
  assign accept   = in_valid && !in_stall;

  // shift-add-3 over four magnitude bits per cycle
  always_comb begin
    bcd_next = bcd;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BCD_W-2:0], mag[MAG_W-1-b]};
    end
  end

  // digit count from the highest nonzero digit, zero still prints one
  always_comb begin
    ndig = 4'd1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        ndig = 4'(d + 1);
      end
    end
  end

  assign lz                = 4'(NUM_DIGITS) - ndig;
  assign push_data.neg     = neg;
  assign push_data.ndig    = ndig;
  assign push_data.digits  = bcd << {lz, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (step == STEP_W'(NUM_STEPS - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push) begin
            state <= accept ? ST_CONV : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg  <= value[31];
      mag  <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
      bcd  <= '0;
      step <= '0;
    end else if (state == ST_CONV) begin
      bcd  <= bcd_next;
      mag  <= mag << BITS_PER_STEP;
      step <= step + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/sbad_back.sv =====
// back part: prints one queued number a character per cycle while out_stall is low
module sbad_back (
  input  logic               clk,
  input  logic               rst,
  output logic               pop,
  input  sbad_pkg::q_entry_t pop_data,
  input  logic               empty,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         char_code,
  output logic               last_char
);
  import sbad_pkg::*;

  logic             busy;
  logic             sign_pend;
  logic [BCD_W-1:0] digits;
  logic [3:0]       left;
  logic             emit;
  logic             finishing;

  assign emit      = busy && (!out_valid || !out_stall);
  assign finishing = emit && !sign_pend && (left == 4'd1);
  // next number loads in the cycle the last character goes out
  assign pop       = (!busy || finishing) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (sign_pend) begin
        char_code <= CHAR_MINUS;
        last_char <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + {4'd0, digits[BCD_W-1 -: 4]};
        last_char <= (left == 4'd1);
      end
    end
    if (pop) begin
      sign_pend <= pop_data.neg;
      digits    <= pop_data.digits;
      left      <= pop_data.ndig;
    end else if (emit) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        digits <= digits << 4;
        left   <= left - 4'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/signed_binary_to_ascii_decimal.sv =====
// top level: signed 32-bit integer to decimal ascii text
//
//   channel  signals                       per word
//   in       in_valid in_stall value       one signed 32-bit integer
//   out      out_valid out_stall           one character, last_char on the final
//            char_code last_char
//
// conversion runs from accept to queue as shift-add-3 steps, four bits each,
// then the push, which waits while the queue is full; printing puts out the
// characters in order, 1 to 11 per number. the queue lets conversion of the
// next number overlap printing. rst is synchronous and empties the queue and
// the output register. out_stall holds the output character; in_stall rises
// while a conversion runs or a converted number waits on a full queue.
module signed_binary_to_ascii_decimal #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         char_code,
  output logic               last_char
);
  import sbad_pkg::*;

  q_entry_t push_data;
  q_entry_t pop_data;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  sbad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // depth of at least 2
  sbad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  sbad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

// ===== hw/rtl/sbad_checker.sv =====
// port checker for the decimal text converter and its bind
`include "signed_binary_to_ascii_decimal_defines.svh"

module sbad_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  char_code,
  input logic        last_char
);
  import sbad_pkg::*;

  // a word just taken holds off the next one while it converts
  `SBAD_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && !in_stall, in_stall,
    "input taken right after an accepted word")

  // a stalled output word holds
  `SBAD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(char_code) && $stable(last_char),
    "output word changed under stall")

  // only a minus sign or a digit leaves
  `SBAD_ASSERT_IMPL(a_char_set, clk, rst, out_valid,
    (char_code == CHAR_MINUS) || ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)),
    "character outside sign and digits")

  // a minus sign never ends a number
  `SBAD_ASSERT_IMPL(a_minus_not_last, clk, rst, out_valid && (char_code == CHAR_MINUS),
    !last_char, "minus sign flagged as last")

  // a minus sign only opens a number
  `SBAD_ASSERT_NEXT(a_minus_first, clk, rst, out_valid && !out_stall && !last_char,
    !(out_valid && (char_code == CHAR_MINUS)), "minus sign inside a number")

endmodule

bind signed_binary_to_ascii_decimal sbad_checker u_sbad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .char_code (char_code),
  .last_char (last_char)
);

// ===== tb/decimal_text_checker.sv =====
// checker for the decimal text converter: predicts the characters of each number and compares
module decimal_text_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  output int                 mismatches,
  output int                 pending_chars
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbad_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    mismatches    = 0;
    pending_chars = 0;
  end

  // magnitude is taken as unsigned so the most negative word prints in full
  function automatic void queue_decimal_text(input logic [31:0] word);
    logic [31:0] mag;
    logic [7:0]  digit_codes[10];
    int          ndig;
    mag  = word[31] ? (32'd0 - word) : word;
    ndig = 0;
    do begin
      digit_codes[ndig] = CHAR_ZERO + 8'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 32'd0 && ndig < 10);
    if (word[31]) begin
      expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      expected_text.push_back('{code: digit_codes[k], last: (k == 0)});
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    int         errs;
    errs = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        queue_decimal_text(value);
      end
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual code %0d last %0b",
                   $time, char_code, last_char);
          errs++;
        end else begin
          want = expected_text.pop_front();
          if (char_code !== want.code) begin
            $display("%0t: char_code: expected %0d, actual %0d", $time, want.code, char_code);
            errs++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char: expected %0b, actual %0b", $time, want.last, last_char);
            errs++;
          end
        end
      end
    end
    mismatches    <= mismatches + errs;
    pending_chars <= expected_text.size();
  end

endmodule

// ===== tb/signed_binary_to_ascii_decimal_tb.sv =====
// testbench top: drives numbers into the decimal text converter and reports the verdict
module signed_binary_to_ascii_decimal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 460;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [31:0] value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         char_code;
  logic               last_char;
  logic               quiet     = 1'b0;
  int                 mismatches;
  int                 pending_chars;

  always #5 clk = ~clk;

  signed_binary_to_ascii_decimal i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last_char (last_char)
  );

  decimal_text_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_code     (char_code),
    .last_char     (last_char),
    .mismatches    (mismatches),
    .pending_chars (pending_chars)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 16);
  end

  // valid stays high across back-to-back words, it only drops for a gap
  task automatic send_word(input logic signed [31:0] word);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 16);
    end
    in_valid <= 1'b1;
    value    <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // magnitude with a chosen digit count, either sign
  function automatic logic signed [31:0] word_with_digits(input int ndig, input bit neg);
    longint lo, hi, mag;
    lo  = 1;
    for (int k = 1; k < ndig; k++) lo = lo * 10;
    hi  = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'd2147483647 + neg) hi = 64'd2147483647 + neg;
    mag = $urandom_range(int'(hi), int'(lo));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  initial begin
    logic signed [31:0] directed[$];
    longint             p;
    int                 sel;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, 32'sd12345, -32'sd12345, 32'sd999999999, 32'sd1000000000,
                 -32'sd1000000000, 32'sd2147483647, -32'sd2147483647, 32'sd2147483646,
                 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd7, 32'h7FFF_FFF0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i]);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet <= (n >= 200 && n < 280);
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        send_word($urandom);
      end else if (sel < 85) begin
        send_word(word_with_digits($urandom_range(1, 10), $urandom_range(0, 1)));
      end else begin
        // straddle a power of ten
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        p = p + $urandom_range(0, 2) - 1;
        send_word($urandom_range(0, 1) ? 32'(-p) : 32'(p));
      end
    end
    in_valid <= 1'b0;
    quiet    <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
